[rtl/core/gcvu_pkg.sv]
// Shared widths, sequencer states and constants for the group collision velocity block.
package gcvu_pkg;

   localparam int MASS_IN_W  = 16;
   localparam int MASS_WIDTH = 16;
   localparam int VEL_W      = 32;

   // Signed product of a zero-extended mass and a velocity.
   localparam int PROD_W  = MASS_WIDTH + 1 + VEL_W;
   // Sum of two products.
   localparam int NUM_W   = PROD_W + 1;
   localparam int SUM_W   = MASS_WIDTH + 1;
   // Two quotient bits are produced per divider cycle.
   localparam int DIV_STEPS = (NUM_W + 1) / 2;
   localparam int DIV_W     = 2 * DIV_STEPS;
   localparam int CNT_W     = $clog2(DIV_STEPS + 1);
   localparam int CM_W      = NUM_W + 1;
   localparam int RES_W     = CM_W + 2;

   localparam logic WHICH_PARTNER = 1'b0;
   localparam logic WHICH_HELD    = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_ACCUM,
      ST_DIV_LOAD,
      ST_DIV_WAIT,
      ST_UPDATE,
      ST_EMIT_PART,
      ST_EMIT_HELD
   } state_type;

endpackage

[rtl/core/gcvu_req_if.sv]
// Request channel: one object of a collision group.
interface gcvu_req_if;
   import gcvu_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [MASS_IN_W-1:0]   mass;
   logic signed [VEL_W-1:0] vel_x;
   logic signed [VEL_W-1:0] vel_y;
   logic                   group_start;
   logic                   group_end;

   modport source (output valid, mass, vel_x, vel_y, group_start, group_end, input ready);
   modport sink (input valid, mass, vel_x, vel_y, group_start, group_end, output ready);
endinterface

[rtl/core/gcvu_rsp_if.sv]
// Response channel: one updated object velocity.
interface gcvu_rsp_if;
   import gcvu_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [VEL_W-1:0] new_vel_x;
   logic signed [VEL_W-1:0] new_vel_y;
   logic                    which_object;
   logic                    mass_sum_zero;
   logic                    last;

   modport source (output valid, new_vel_x, new_vel_y, which_object, mass_sum_zero, last,
                   input ready);
   modport sink (input valid, new_vel_x, new_vel_y, which_object, mass_sum_zero, last,
                 output ready);
endinterface

[rtl/core/gcvu_div.sv]
// Iterative restoring divider, unsigned, two quotient bits per cycle.
module gcvu_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [gcvu_pkg::DIV_W-1:0]  dividend,
   input  logic [gcvu_pkg::SUM_W-1:0]  divisor,
   output logic                        done,
   output logic [gcvu_pkg::DIV_W-1:0]  quotient
);
   import gcvu_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [SUM_W-1:0] rem_ff, rem_in;

   logic [SUM_W:0]   step1, step2;

   // One restoring step: returns the new remainder and the quotient bit.
   function automatic logic [SUM_W:0] div_step(input logic [SUM_W-1:0] rem,
                                               input logic              nbit,
                                               input logic [SUM_W-1:0] d);
      logic [SUM_W:0] trial;
      logic [SUM_W:0] diff;
      trial = {rem, nbit};
      diff  = trial - {1'b0, d};
      if (trial >= {1'b0, d}) begin
         div_step = {diff[SUM_W-1:0], 1'b1};
      end else begin
         div_step = {rem[SUM_W-2:0], nbit, 1'b0};
      end
   endfunction

   always_comb begin
      step1 = div_step(rem_ff, quo_ff[DIV_W-1], divisor);
      step2 = div_step(step1[SUM_W:1], quo_ff[DIV_W-2], divisor);
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_STEPS);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_W-3:0], step1[0], step2[0]};
         rem_in = step2[SUM_W:1];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");
   a_count_zero_when_idle: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cnt_ff == CNT_W'(1) && !start) |=> (done_ff && !busy_ff))
      else $error("divider did not finish on its last iteration");
   a_busy_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0)
      else $error("divider busy with an exhausted count");

endmodule

[rtl/core/group_collision_velocity_update.sv]
// Top level: sequencer, shared multiplier and velocity update for grouped elastic collisions.
//
// A group-start request only stores the held object, and one that also ends the group
// costs one response. A partner request with a nonzero mass sum runs both axes through
// one 17x32 multiplier and one iterative divider: per axis the states MUL_A and MUL_B
// and an accumulate state, a divider load state, the wait state over the divider's
// iterations at two quotient bits each until the quotient is presented, and an update
// state, all of which a zero mass sum skips; then come the partner response and, if the
// request ends the group, the held response, both stalled while the response side holds
// ready low. The block takes no new request until every response of this one is taken.
module group_collision_velocity_update (
   input  logic        clock,
   input  logic        reset,
   gcvu_req_if.sink    req_chan,
   gcvu_rsp_if.source  rsp_chan
);
   import gcvu_pkg::*;

   state_type state_ff, state_in;

   logic                     axis_ff, axis_in;
   logic [MASS_WIDTH-1:0]    mass_ff, mass_in;
   logic signed [VEL_W-1:0]  vel_ff [2];
   logic signed [VEL_W-1:0]  vel_in [2];
   logic [MASS_WIDTH-1:0]    held_mass_ff, held_mass_in;
   logic signed [VEL_W-1:0]  held_vel_ff [2];
   logic signed [VEL_W-1:0]  held_vel_in [2];
   logic                     end_ff, end_in;
   logic                     zero_ff, zero_in;
   logic [SUM_W-1:0]         msum_ff, msum_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [NUM_W-1:0]  acc_ff, acc_in;

   logic                     req_fire;
   logic                     rsp_fire;
   logic [SUM_W-1:0]         msum_new;
   logic                     mul_sel_held;
   logic [MASS_WIDTH-1:0]    mul_mass;
   logic signed [VEL_W-1:0]  mul_vel;
   logic signed [PROD_W-1:0] product;
   logic signed [NUM_W-1:0]  prod_ext;
   logic [NUM_W-1:0]         acc_mag;
   logic                     div_start;
   logic                     div_done;
   logic [DIV_W-1:0]         div_quo;
   logic signed [CM_W-1:0]   cm_pos;
   logic signed [CM_W-1:0]   cm;

   // 2*cm - v, clamped to the signed velocity range.
   function automatic logic signed [VEL_W-1:0] update_vel(input logic signed [CM_W-1:0] c,
                                                          input logic signed [VEL_W-1:0] v);
      logic signed [RES_W-1:0] c_x;
      logic signed [RES_W-1:0] v_x;
      logic signed [RES_W-1:0] r;
      c_x = {{(RES_W - CM_W){c[CM_W-1]}}, c};
      v_x = {{(RES_W - VEL_W){v[VEL_W-1]}}, v};
      r   = (c_x <<< 1) - v_x;
      if (r[RES_W-1:VEL_W-1] == '0 || r[RES_W-1:VEL_W-1] == '1) begin
         update_vel = r[VEL_W-1:0];
      end else if (r[RES_W-1]) begin
         update_vel = {1'b1, {(VEL_W-1){1'b0}}};
      end else begin
         update_vel = {1'b0, {(VEL_W-1){1'b1}}};
      end
   endfunction

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign msum_new = {1'b0, held_mass_ff} + {1'b0, req_chan.mass[MASS_WIDTH-1:0]};

   // Shared multiplier: held operand first, partner operand second.
   assign mul_mass = mul_sel_held ? held_mass_ff : mass_ff;
   assign mul_vel  = mul_sel_held ? held_vel_ff[axis_ff] : vel_ff[axis_ff];
   assign product  = $signed({1'b0, mul_mass}) * mul_vel;
   assign prod_ext = {prod_ff[PROD_W-1], prod_ff};
   assign acc_mag  = acc_ff[NUM_W-1] ? NUM_W'(-acc_ff) : NUM_W'(acc_ff);

   assign cm_pos = $signed({1'b0, div_quo[NUM_W-1:0]});
   assign cm     = acc_ff[NUM_W-1] ? -cm_pos : cm_pos;

   gcvu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (DIV_W'(acc_mag)),
      .divisor  (msum_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.group_start) begin
                  state_in = req_chan.group_end ? ST_EMIT_HELD : ST_IDLE;
               end else if (msum_new == '0) begin
                  state_in = ST_EMIT_PART;
               end else begin
                  state_in = ST_MUL_A;
               end
            end
         end
         ST_MUL_A:    state_in = ST_MUL_B;
         ST_MUL_B:    state_in = ST_ACCUM;
         ST_ACCUM:    state_in = ST_DIV_LOAD;
         ST_DIV_LOAD: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE:   state_in = axis_ff ? ST_EMIT_PART : ST_MUL_A;
         ST_EMIT_PART: begin
            if (rsp_fire) begin
               state_in = end_ff ? ST_EMIT_HELD : ST_IDLE;
            end
         end
         ST_EMIT_HELD: begin
            if (rsp_fire) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // Handshake and control outputs.
   always_comb begin
      req_chan.ready         = 1'b0;
      rsp_chan.valid         = 1'b0;
      rsp_chan.new_vel_x     = vel_ff[0];
      rsp_chan.new_vel_y     = vel_ff[1];
      rsp_chan.which_object  = WHICH_PARTNER;
      rsp_chan.mass_sum_zero = zero_ff;
      rsp_chan.last          = !end_ff;
      div_start              = 1'b0;
      mul_sel_held           = 1'b0;
      unique case (state_ff)
         ST_IDLE:      req_chan.ready = 1'b1;
         ST_MUL_A:     mul_sel_held = 1'b1;
         ST_DIV_LOAD:  div_start = 1'b1;
         ST_EMIT_PART: rsp_chan.valid = 1'b1;
         ST_EMIT_HELD: begin
            rsp_chan.valid         = 1'b1;
            rsp_chan.new_vel_x     = held_vel_ff[0];
            rsp_chan.new_vel_y     = held_vel_ff[1];
            rsp_chan.which_object  = WHICH_HELD;
            rsp_chan.mass_sum_zero = 1'b0;
            rsp_chan.last          = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Datapath register updates.
   always_comb begin
      axis_in      = axis_ff;
      mass_in      = mass_ff;
      vel_in       = vel_ff;
      held_mass_in = held_mass_ff;
      held_vel_in  = held_vel_ff;
      end_in       = end_ff;
      zero_in      = zero_ff;
      msum_in      = msum_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               mass_in   = req_chan.mass[MASS_WIDTH-1:0];
               vel_in[0] = req_chan.vel_x;
               vel_in[1] = req_chan.vel_y;
               end_in    = req_chan.group_end;
               zero_in   = (msum_new == '0);
               msum_in   = msum_new;
               axis_in   = 1'b0;
               if (req_chan.group_start) begin
                  held_mass_in   = req_chan.mass[MASS_WIDTH-1:0];
                  held_vel_in[0] = req_chan.vel_x;
                  held_vel_in[1] = req_chan.vel_y;
               end
            end
         end
         ST_MUL_A: prod_in = product;
         ST_MUL_B: begin
            prod_in = product;
            acc_in  = prod_ext;
         end
         ST_ACCUM: acc_in = acc_ff + prod_ext;
         ST_UPDATE: begin
            held_vel_in[axis_ff] = update_vel(cm, held_vel_ff[axis_ff]);
            vel_in[axis_ff]      = update_vel(cm, vel_ff[axis_ff]);
            axis_in              = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         held_mass_ff   <= '0;
         held_vel_ff[0] <= '0;
         held_vel_ff[1] <= '0;
      end else begin
         state_ff     <= state_in;
         held_mass_ff <= held_mass_in;
         held_vel_ff  <= held_vel_in;
      end
      axis_ff <= axis_in;
      mass_ff <= mass_in;
      vel_ff  <= vel_in;
      end_ff  <= end_in;
      zero_ff <= zero_in;
      msum_ff <= msum_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   a_held_result_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.which_object == WHICH_HELD)
         |-> (rsp_chan.last && !rsp_chan.mass_sum_zero))
      else $error("held object result not marked last or flagged zero");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !rsp_chan.valid)
      else $error("request accepted while a response is pending");
   a_start_only_holds: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.group_start && !req_chan.group_end) |=> state_ff == ST_IDLE)
      else $error("group start without end produced work");
   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV_WAIT)
      else $error("divider finished outside of its wait state");
   a_zero_sum_skips_math: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_chan.group_start && msum_new == '0) |=> state_ff == ST_EMIT_PART)
      else $error("zero mass sum did not go straight to the partner response");

endmodule

[tb/testbench.sv]
// Self-checking testbench for the grouped elastic collision velocity update block.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import gcvu_pkg::*;

   localparam logic signed [VEL_W-1:0] VEL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VEL_W-1:0] VEL_MIN = 32'sh8000_0000;
   localparam int RANDOM_ITEMS = 750;

   typedef struct {
      logic [MASS_IN_W-1:0]    mass;
      logic signed [VEL_W-1:0] vel_x;
      logic signed [VEL_W-1:0] vel_y;
      logic                    group_start;
      logic                    group_end;
      bit                      drain_first;
   } object_type;

   typedef struct {
      logic signed [VEL_W-1:0] new_vel_x;
      logic signed [VEL_W-1:0] new_vel_y;
      logic                    which_object;
      logic                    mass_sum_zero;
      logic                    last;
   } velocity_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gcvu_req_if req_bus ();
   gcvu_rsp_if rsp_bus ();

   group_collision_velocity_update dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   object_type   pending_objects[$];
   velocity_type expected_velocities[$];
   object_type   current_object;
   int           mismatch_count = 0;
   bit           drain_next = 1'b0;
   int           req_hold = 0;
   int           rsp_hold = 0;
   int           req_calm = 0;
   int           rsp_calm = 0;

   // Our own copy of the held object.
   longint held_mass  = 0;
   longint held_vel_x = 0;
   longint held_vel_y = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   // Mostly random waits, with occasional runs of back-to-back transfers.
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(0, 17);
   endfunction

   function automatic longint clamp_velocity(input longint v);
      if (v > longint'(VEL_MAX)) return longint'(VEL_MAX);
      if (v < longint'(VEL_MIN)) return longint'(VEL_MIN);
      return v;
   endfunction

   // One axis of an elastic collision: both velocities reflect about the
   // center-of-mass velocity, which is truncated toward zero.
   function automatic void collide_axis(input longint mass_a, input longint mass_b,
                                        inout longint vel_a, inout longint vel_b);
      longint center;
      center = (mass_a * vel_a + mass_b * vel_b) / (mass_a + mass_b);
      vel_a  = clamp_velocity(2 * center - vel_a);
      vel_b  = clamp_velocity(2 * center - vel_b);
   endfunction

   function automatic void collide_object(input object_type obj);
      longint       obj_mass;
      longint       vx;
      longint       vy;
      velocity_type res;
      obj_mass = obj.mass;
      vx = obj.vel_x;
      vy = obj.vel_y;
      if (obj.group_start) begin
         held_mass  = obj_mass;
         held_vel_x = vx;
         held_vel_y = vy;
      end else begin
         res.mass_sum_zero = (held_mass + obj_mass == 0);
         if (!res.mass_sum_zero) begin
            collide_axis(held_mass, obj_mass, held_vel_x, vx);
            collide_axis(held_mass, obj_mass, held_vel_y, vy);
         end
         res.new_vel_x    = vx[VEL_W-1:0];
         res.new_vel_y    = vy[VEL_W-1:0];
         res.which_object = WHICH_PARTNER;
         res.last         = !obj.group_end;
         expected_velocities.push_back(res);
      end
      if (obj.group_end) begin
         res.new_vel_x     = held_vel_x[VEL_W-1:0];
         res.new_vel_y     = held_vel_y[VEL_W-1:0];
         res.which_object  = WHICH_HELD;
         res.mass_sum_zero = 1'b0;
         res.last          = 1'b1;
         expected_velocities.push_back(res);
      end
   endfunction

   function automatic void add_object(input logic [MASS_IN_W-1:0] mass,
                                      input logic signed [VEL_W-1:0] vel_x,
                                      input logic signed [VEL_W-1:0] vel_y,
                                      input logic group_start, input logic group_end);
      object_type obj;
      obj.mass        = mass;
      obj.vel_x       = vel_x;
      obj.vel_y       = vel_y;
      obj.group_start = group_start;
      obj.group_end   = group_end;
      obj.drain_first = drain_next;
      drain_next      = 1'b0;
      pending_objects.push_back(obj);
   endfunction

   function automatic logic [MASS_IN_W-1:0] random_mass();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return MASS_IN_W'($urandom_range(1, 16));
         default: return MASS_IN_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [VEL_W-1:0] random_velocity();
      case ($urandom_range(0, 7))
         0: return VEL_MAX;
         1: return VEL_MIN;
         2: return VEL_W'(int'($urandom_range(0, 2 << 16)) - (1 << 16));
         default: return VEL_W'($urandom);
      endcase
   endfunction

   function automatic void report_field(input string name, input longint want,
                                        input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : drive_requests
      logic offer;
      offer = req_bus.valid;
      if (reset) begin
         offer    = 1'b0;
         req_hold = draw_wait(req_calm);
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            collide_object(current_object);
            offer    = 1'b0;
            req_hold = draw_wait(req_calm);
         end
         if (!offer) begin
            if (req_hold > 0) begin
               req_hold--;
            end else if (pending_objects.size() != 0 &&
                         !(pending_objects[0].drain_first &&
                           expected_velocities.size() != 0)) begin
               current_object          = pending_objects.pop_front();
               offer                   = 1'b1;
               req_bus.mass           <= current_object.mass;
               req_bus.vel_x          <= current_object.vel_x;
               req_bus.vel_y          <= current_object.vel_y;
               req_bus.group_start    <= current_object.group_start;
               req_bus.group_end      <= current_object.group_end;
            end
         end
      end
      req_bus.valid <= offer;
   end

   always @(posedge clock) begin : collect_responses
      velocity_type want;
      if (reset) begin
         rsp_hold = draw_wait(rsp_calm);
      end else if (rsp_bus.valid && rsp_bus.ready) begin
         if (expected_velocities.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual x %0d y %0d",
                     $time, rsp_bus.new_vel_x, rsp_bus.new_vel_y);
            mismatch_count++;
         end else begin
            want = expected_velocities.pop_front();
            report_field("new_vel_x", want.new_vel_x, rsp_bus.new_vel_x);
            report_field("new_vel_y", want.new_vel_y, rsp_bus.new_vel_y);
            report_field("which_object", want.which_object, rsp_bus.which_object);
            report_field("mass_sum_zero", want.mass_sum_zero, rsp_bus.mass_sum_zero);
            report_field("last", want.last, rsp_bus.last);
         end
         rsp_hold = draw_wait(rsp_calm);
      end
      if (reset || rsp_hold > 0) begin
         if (rsp_hold > 0) rsp_hold--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   initial begin
      int group_size;
      int group_count;
      bit drop_end;
      req_bus.valid       = 1'b0;
      req_bus.mass        = '0;
      req_bus.vel_x       = '0;
      req_bus.vel_y       = '0;
      req_bus.group_start = 1'b0;
      req_bus.group_end   = 1'b0;
      rsp_bus.ready       = 1'b0;

      // A partner straight after reset meets the zero-mass held object.
      add_object(0, 32'sh0001_8000, -32'sh0000_4000, 1'b0, 1'b0);
      // Held mass is still zero, so held velocity is twice the partner's, saturated.
      add_object(5, VEL_MAX, VEL_MIN, 1'b0, 1'b0);
      // A group of a single object.
      add_object('1, VEL_MIN, VEL_MAX, 1'b1, 1'b1);
      // Equal masses at opposite extremes: the center velocity truncates toward zero.
      add_object('1, VEL_MAX, VEL_MIN, 1'b1, 1'b0);
      add_object('1, VEL_MIN, VEL_MAX, 1'b0, 1'b1);
      // Both masses zero inside a group, then the held final result.
      add_object(0, 1234, -99, 1'b1, 1'b0);
      add_object(0, -7, 8, 1'b0, 1'b1);
      // A light partner against a heavy fast object saturates both ways.
      add_object('1, VEL_MAX, VEL_MAX, 1'b1, 1'b0);
      add_object(1, VEL_MIN, VEL_MIN, 1'b0, 1'b1);
      add_object('1, VEL_MIN, VEL_MIN, 1'b1, 1'b0);
      add_object(1, VEL_MAX, VEL_MAX, 1'b0, 1'b1);
      // Three objects with small velocities.
      add_object(3, 32'sh0002_0000, -32'sh0001_0000, 1'b1, 1'b0);
      add_object(1, -1, 1, 1'b0, 1'b0);
      add_object(7, 0, 1, 1'b0, 1'b1);
      // An unfinished group is silently replaced by the next start.
      add_object(10, 100, 200, 1'b1, 1'b0);
      add_object(20, -300, 400, 1'b1, 1'b0);
      add_object(30, 5, -5, 1'b0, 1'b0);
      drain_next = 1'b1;
      add_object(0, 32'sh0000_0003, -32'sh0000_0003, 1'b0, 1'b1);
      // A lone partner that also ends the group, with no start before it.
      add_object(2, -3, 3, 1'b0, 1'b1);

      group_count = 0;
      while (pending_objects.size() < RANDOM_ITEMS + 19) begin
         group_count++;
         if (group_count % 60 == 30) drain_next = 1'b1;
         if ($urandom_range(0, 9) == 0) begin
            add_object(random_mass(), random_velocity(), random_velocity(),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else begin
            group_size = $urandom_range(1, 5);
            drop_end   = ($urandom_range(0, 9) == 0);
            add_object(random_mass(), random_velocity(), random_velocity(), 1'b1,
                       group_size == 1 && !drop_end);
            for (int i = 1; i < group_size; i++) begin
               add_object(random_mass(), random_velocity(), random_velocity(), 1'b0,
                          i == group_size - 1 && !drop_end);
            end
         end
      end

      @(negedge reset);
      while (pending_objects.size() != 0 || req_bus.valid ||
             expected_velocities.size() != 0)
         @(posedge clock);
      repeat (150) @(posedge clock);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
